FILE: design/brb_pkg.sv
// Shared constants, request codes and the result record for the byte ring buffer.
package brb_pkg;

  localparam int DEPTH_DEF    = 4096;
  localparam int MAX_XFER_DEF = 64;

  localparam int LEN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int HELD_W  = 13;
  localparam int TOTAL_W = 32;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_PEEK   = 2'd2;
  localparam logic [1:0] REQ_REMOVE = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               last;
    logic               status;
    logic [HELD_W-1:0]  bytes_held;
    logic [TOTAL_W-1:0] total_written;
  } result_t;

endpackage

FILE: design/brb_store.sv
// Byte storage: one write port and one registered read port.
module brb_store #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [brb_pkg::BYTE_W-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [brb_pkg::BYTE_W-1:0] rd_data
);

  logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/brb_ctrl.sv
// Pointer, count and write-run control plus the read/peek byte streamer.
module brb_ctrl #(
  parameter int DEPTH    = brb_pkg::DEPTH_DEF,
  parameter int MAX_XFER = brb_pkg::MAX_XFER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [brb_pkg::LEN_W-1:0]   length,
  input  logic [brb_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        data_last,
  input  logic                        out_free,
  output logic                        res_load,
  output brb_pkg::result_t            res,
  output logic                        wr_en,
  output logic [$clog2(DEPTH)-1:0]    wr_addr,
  output logic [brb_pkg::BYTE_W-1:0]  wr_data,
  output logic [$clog2(DEPTH)-1:0]    rd_addr,
  input  logic [brb_pkg::BYTE_W-1:0]  rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int HW = $clog2(DEPTH + 1);
  localparam int SW = ((HW > brb_pkg::LEN_W) ? HW : brb_pkg::LEN_W) + 1;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  logic                         state, state_next;
  logic [PW-1:0]                rp, rp_next;
  logic [PW-1:0]                wp, wp_next;
  logic [HW-1:0]                held, held_next;
  logic [brb_pkg::TOTAL_W-1:0]  total, total_next;
  logic [brb_pkg::LEN_W-1:0]    write_left, write_left_next;
  logic                         write_dropping, write_dropping_next;
  logic                         write_open, write_open_next;
  logic [PW-1:0]                cur, cur_next;
  logic [brb_pkg::LEN_W-1:0]    cnt, cnt_next;

  logic                         accept;
  logic                         open_drop;
  logic [brb_pkg::LEN_W-1:0]    open_left;
  logic                         too_long;
  logic [SW-1:0]                rp_sum;
  logic [PW-1:0]                rp_adv;
  logic [PW-1:0]                wp_inc;
  logic [PW-1:0]                cur_inc;

  assign in_stall = (state != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign wp_inc  = (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
  assign cur_inc = (cur == PW'(DEPTH - 1)) ? '0 : cur + PW'(1);

  // read pointer after consuming length bytes; sum stays below twice the depth
  always_comb begin
    rp_sum = SW'(rp) + SW'(length);
    if (rp_sum >= SW'(DEPTH)) begin
      rp_sum = rp_sum - SW'(DEPTH);
    end
    rp_adv = rp_sum[PW-1:0];
  end

  assign too_long = (SW'(length) > SW'(held)) ||
                    (length > brb_pkg::LEN_W'(MAX_XFER));

  assign wr_addr = wp;
  assign wr_data = data_byte;

  // keep the streamer one byte ahead: fetch the next address as a byte leaves
  always_comb begin
    if (state == ST_STREAM) begin
      rd_addr = out_free ? cur_inc : cur;
    end else begin
      rd_addr = rp;
    end
  end

  always_comb begin
    state_next          = state;
    rp_next             = rp;
    wp_next             = wp;
    held_next           = held;
    total_next          = total;
    write_left_next     = write_left;
    write_dropping_next = write_dropping;
    write_open_next     = write_open;
    cur_next            = cur;
    cnt_next            = cnt;
    wr_en               = 1'b0;
    res_load            = 1'b0;
    res                 = '0;
    open_drop           = write_dropping;
    open_left           = write_left;

    if (state == ST_STREAM) begin
      if (out_free) begin
        res_load            = 1'b1;
        res.out_byte        = rd_data;
        res.byte_valid      = 1'b1;
        res.last            = (cnt == brb_pkg::LEN_W'(1));
        res.bytes_held      = brb_pkg::HELD_W'(held);
        res.total_written   = total;
        cur_next            = cur_inc;
        cnt_next            = cnt - brb_pkg::LEN_W'(1);
        if (cnt == brb_pkg::LEN_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
    end else if (accept) begin
      if (req_type == brb_pkg::REQ_WRITE) begin
        // length is checked only on the first item of a run
        if (!write_open) begin
          open_drop = (length > brb_pkg::LEN_W'(MAX_XFER)) ||
                      (SW'(held) + SW'(length) > SW'(DEPTH));
          open_left = open_drop ? '0 : length;
        end
        write_open_next     = 1'b1;
        write_dropping_next = open_drop;
        write_left_next     = open_left;
        if (!open_drop && open_left != '0 && held != HW'(DEPTH)) begin
          wr_en           = 1'b1;
          wp_next         = wp_inc;
          held_next       = held + HW'(1);
          total_next      = total + brb_pkg::TOTAL_W'(1);
          write_left_next = open_left - brb_pkg::LEN_W'(1);
        end
        if (data_last) begin
          write_open_next     = 1'b0;
          write_dropping_next = 1'b0;
          write_left_next     = '0;
          res_load            = 1'b1;
          res.last            = 1'b1;
          res.status          = open_drop;
          res.bytes_held      = brb_pkg::HELD_W'(held_next);
          res.total_written   = total_next;
        end
      end else if (too_long) begin
        res_load          = 1'b1;
        res.last          = 1'b1;
        res.status        = 1'b1;
        res.bytes_held    = brb_pkg::HELD_W'(held);
        res.total_written = total;
      end else begin
        if (req_type != brb_pkg::REQ_PEEK) begin
          held_next = held - HW'(length);
          rp_next   = rp_adv;
          if (held == HW'(length)) begin
            rp_next = '0;
            wp_next = '0;
          end
        end
        if ((req_type == brb_pkg::REQ_READ || req_type == brb_pkg::REQ_PEEK) &&
            length != '0) begin
          state_next = ST_STREAM;
          cur_next   = rp;
          cnt_next   = length;
        end else begin
          res_load          = 1'b1;
          res.last          = 1'b1;
          res.bytes_held    = brb_pkg::HELD_W'(held_next);
          res.total_written = total;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      rp             <= '0;
      wp             <= '0;
      held           <= '0;
      total          <= '0;
      write_left     <= '0;
      write_dropping <= 1'b0;
      write_open     <= 1'b0;
    end else begin
      state          <= state_next;
      rp             <= rp_next;
      wp             <= wp_next;
      held           <= held_next;
      total          <= total_next;
      write_left     <= write_left_next;
      write_dropping <= write_dropping_next;
      write_open     <= write_open_next;
    end
    cur <= cur_next;
    cnt <= cnt_next;
  end

endmodule

FILE: design/byte_ring_buffer_peek_top.sv
// Top level of the byte ring buffer with peek: control, byte store, result register.
//
//   channel | valid    | stall     | payload
//   --------+----------+-----------+------------------------------------------------
//   input   | in_valid | in_stall  | req_type, length, data_byte, data_last
//   output  | out_valid| out_stall | out_byte, byte_valid, last, status,
//           |          |           | bytes_held, total_written
//
// Write items, removes and rejected or empty requests are handled as they are accepted.
// A read or peek first reads the store's single registered read port and then
// delivers one byte per cycle while the output is not stalled.
// rst is synchronous; the byte store is not cleared and needs no clearing pass.
// out_stall holds the result register; input is stalled while a result waits
// to be taken or a read/peek is still streaming.
module byte_ring_buffer_peek_top #(
  parameter int DEPTH    = brb_pkg::DEPTH_DEF,
  parameter int MAX_XFER = brb_pkg::MAX_XFER_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   req_type,
  input  logic [brb_pkg::LEN_W-1:0]    length,
  input  logic [brb_pkg::BYTE_W-1:0]   data_byte,
  input  logic                         data_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [brb_pkg::BYTE_W-1:0]   out_byte,
  output logic                         byte_valid,
  output logic                         last,
  output logic                         status,
  output logic [brb_pkg::HELD_W-1:0]   bytes_held,
  output logic [brb_pkg::TOTAL_W-1:0]  total_written
);

  localparam int PW = $clog2(DEPTH);

  logic                        out_free;
  logic                        res_load;
  brb_pkg::result_t            res;
  brb_pkg::result_t            res_q;
  logic                        wr_en;
  logic [PW-1:0]               wr_addr;
  logic [brb_pkg::BYTE_W-1:0]  wr_data;
  logic [PW-1:0]               rd_addr;
  logic [brb_pkg::BYTE_W-1:0]  rd_data;

  assign out_free = !out_valid || !out_stall;

  brb_ctrl #(
    .DEPTH    (DEPTH),
    .MAX_XFER (MAX_XFER)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .length    (length),
    .data_byte (data_byte),
    .data_last (data_last),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  brb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_byte      = res_q.out_byte;
  assign byte_valid    = res_q.byte_valid;
  assign last          = res_q.last;
  assign status        = res_q.status;
  assign bytes_held    = res_q.bytes_held;
  assign total_written = res_q.total_written;

endmodule

FILE: design/brb_checker.sv
// Port-level checks for the byte ring buffer, bound to the top level.
module brb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [brb_pkg::BYTE_W-1:0]   out_byte,
  input logic                         byte_valid,
  input logic                         last,
  input logic                         status,
  input logic [brb_pkg::HELD_W-1:0]   bytes_held,
  input logic [brb_pkg::TOTAL_W-1:0]  total_written
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last) &&
                               $stable(status) && $stable(bytes_held))
    else $error("result changed while stalled");

  // a returned byte is never part of a rejected request
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> !status)
    else $error("returned byte flagged as rejected");

  // a status-only result always ends its request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last)
    else $error("status result without last");

  // the running write total never changes between results of one stream
  a_total_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && byte_valid && !last ##1 out_valid |->
      total_written == $past(total_written))
    else $error("write total moved inside a byte stream");

endmodule

bind byte_ring_buffer_peek_top brb_checker u_brb_checker (.*);
